[sv/hsv_to_cmyk_pixel_convert_macros.svh]
// Assertion macros used by the converter's queue.
`ifndef HSV_TO_CMYK_PIXEL_CONVERT_MACROS_SVH
`define HSV_TO_CMYK_PIXEL_CONVERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every rising clock edge out of reset
`define HCC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Condition that must never be seen out of reset
`define HCC_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define HCC_ASSERT(lbl, clk, rstn, prop, msg)
`define HCC_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

[sv/hcc_pkg.sv]
// Types and constants of the HSV to CMYK converter.
package hcc_pkg;

  // Input ranges
  localparam logic [8:0]  HUE_FULL = 9'd360;
  localparam logic [6:0]  PCT_FULL = 7'd100;
  localparam logic [5:0]  SEC_DEG  = 6'd60;
  localparam logic [12:0] FRAC_FULL = 13'd6000;

  // Reciprocals: x/100 = (x*RECIP100)>>19 for x < 43690,
  // x/6000 = (x*RECIP6000)>>33 for x < 6.1e6
  localparam logic [12:0] RECIP100     = 13'd5243;
  localparam int          RECIP100_SH  = 19;
  localparam logic [20:0] RECIP6000    = 21'd1431656;
  localparam int          RECIP6000_SH = 33;

  // Hue sector codes
  localparam logic [2:0] SEC_0 = 3'd0;
  localparam logic [2:0] SEC_1 = 3'd1;
  localparam logic [2:0] SEC_2 = 3'd2;
  localparam logic [2:0] SEC_3 = 3'd3;
  localparam logic [2:0] SEC_4 = 3'd4;
  localparam logic [2:0] SEC_5 = 3'd5;

  // Queue and divider sizes
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int DIV_STEPS  = 8;

  // RGB pixel with its largest channel
  typedef struct packed {
    logic [7:0] mx;
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
  } hcc_item_t;

  // Queue status
  typedef struct packed {
    logic full;
    logic empty;
  } hcc_fifo_stat_t;

endpackage

[sv/hcc_front.sv]
// Front end: HSV to RGB in five pipeline stages, plus the max channel.
module hcc_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  logic [8:0]              hue_deg_i,
  input  logic [6:0]              sat_pct_i,
  input  logic [6:0]              val_pct_i,
  input  hcc_pkg::hcc_fifo_stat_t stat_i,
  output logic                    push_o,
  output hcc_pkg::hcc_item_t      item_o
);
  import hcc_pkg::*;

  logic [4:0] vld_q;
  logic       en;

  // stage A signals
  logic [8:0]  h;
  logic [6:0]  s_c, v_c;
  logic [2:0]  sec;
  logic [8:0]  base;
  logic [5:0]  frac;
  logic [2:0]  sec_a_q;
  logic [6:0]  sat_a_q;
  logic [14:0] vx_a_q;
  logic [12:0] sf_a_q, sg_a_q;
  // stage B
  logic [27:0] v8_prod;
  logic [2:0]  sec_b_q;
  logic        grey_b_q;
  logic [7:0]  v8_b_q;
  logic [6:0]  np_b_q;
  logic [12:0] nq_b_q, nt_b_q;
  // stage C
  logic [2:0]  sec_c_q;
  logic        grey_c_q;
  logic [7:0]  v8_c_q;
  logic [14:0] pa_c_q;
  logic [20:0] qa_c_q, ta_c_q;
  // stage D
  logic [27:0] p_prod;
  logic [41:0] q_prod, t_prod;
  logic [2:0]  sec_d_q;
  logic        grey_d_q;
  logic [7:0]  v8_d_q, p_d_q, q_d_q, t_d_q;
  // stage E
  logic [7:0]  r, g, b, mx;
  hcc_item_t   item_q;

  // whole pipeline moves unless the last stage is blocked by a full queue
  assign en      = !vld_q[4] || !stat_i.full;
  assign ready_o = en;
  assign push_o  = vld_q[4] && !stat_i.full;
  assign item_o  = item_q;

  // stage A: wrap and clamp, sector split, small products
  always_comb begin
    h   = (hue_deg_i >= HUE_FULL) ? hue_deg_i - HUE_FULL : hue_deg_i;
    s_c = (sat_pct_i > PCT_FULL) ? PCT_FULL : sat_pct_i;
    v_c = (val_pct_i > PCT_FULL) ? PCT_FULL : val_pct_i;
    if (h >= 9'd300) begin
      sec = SEC_5; base = 9'd300;
    end else if (h >= 9'd240) begin
      sec = SEC_4; base = 9'd240;
    end else if (h >= 9'd180) begin
      sec = SEC_3; base = 9'd180;
    end else if (h >= 9'd120) begin
      sec = SEC_2; base = 9'd120;
    end else if (h >= 9'd60) begin
      sec = SEC_1; base = 9'd60;
    end else begin
      sec = SEC_0; base = 9'd0;
    end
    frac = 6'(h - base);
  end

  // stage B: V8 and the complement terms
  assign v8_prod = 28'(vx_a_q) * 28'(RECIP100);

  // stage D: scale back by 100 and 6000
  assign p_prod = 28'(pa_c_q) * 28'(RECIP100);
  assign q_prod = 42'(qa_c_q) * 42'(RECIP6000);
  assign t_prod = 42'(ta_c_q) * 42'(RECIP6000);

  // stage E: sector mapping and max
  always_comb begin
    if (grey_d_q) begin
      r = v8_d_q; g = v8_d_q; b = v8_d_q;
    end else begin
      unique case (sec_d_q)
        SEC_0:   begin r = v8_d_q; g = t_d_q;  b = p_d_q;  end
        SEC_1:   begin r = q_d_q;  g = v8_d_q; b = p_d_q;  end
        SEC_2:   begin r = p_d_q;  g = v8_d_q; b = t_d_q;  end
        SEC_3:   begin r = p_d_q;  g = q_d_q;  b = v8_d_q; end
        SEC_4:   begin r = t_d_q;  g = p_d_q;  b = v8_d_q; end
        default: begin r = v8_d_q; g = p_d_q;  b = q_d_q;  end
      endcase
    end
    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (en) begin
      sec_a_q  <= sec;
      sat_a_q  <= s_c;
      vx_a_q   <= {v_c, 8'b0} - {8'b0, v_c};
      sf_a_q   <= 13'(s_c) * 13'(frac);
      sg_a_q   <= 13'(s_c) * 13'(SEC_DEG - frac);

      sec_b_q  <= sec_a_q;
      grey_b_q <= (sat_a_q == '0);
      v8_b_q   <= v8_prod[RECIP100_SH +: 8];
      np_b_q   <= PCT_FULL - sat_a_q;
      nq_b_q   <= FRAC_FULL - sf_a_q;
      nt_b_q   <= FRAC_FULL - sg_a_q;

      sec_c_q  <= sec_b_q;
      grey_c_q <= grey_b_q;
      v8_c_q   <= v8_b_q;
      pa_c_q   <= 15'(v8_b_q) * 15'(np_b_q);
      qa_c_q   <= 21'(v8_b_q) * 21'(nq_b_q);
      ta_c_q   <= 21'(v8_b_q) * 21'(nt_b_q);

      sec_d_q  <= sec_c_q;
      grey_d_q <= grey_c_q;
      v8_d_q   <= v8_c_q;
      p_d_q    <= p_prod[RECIP100_SH +: 8];
      q_d_q    <= q_prod[RECIP6000_SH +: 8];
      t_d_q    <= t_prod[RECIP6000_SH +: 8];

      item_q   <= '{mx: mx, b: b, g: g, r: r};
    end
  end

endmodule

[sv/hcc_fifo.sv]
// Short queue between the front end and the divider back end.
`include "hsv_to_cmyk_pixel_convert_macros.svh"
module hcc_fifo (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  hcc_pkg::hcc_item_t      item_i,
  input  logic                    pop_i,
  output hcc_pkg::hcc_item_t      item_o,
  output hcc_pkg::hcc_fifo_stat_t stat_o
);
  import hcc_pkg::*;

  hcc_item_t            mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [FIFO_AW:0]     cnt_q;

  assign stat_o.full  = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign item_o       = mem_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= item_i;
  end

  `HCC_ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, push_i && stat_o.full, "push into full queue")
  `HCC_ASSERT_NEVER(a_no_underflow, clk_i, rst_ni, pop_i && stat_o.empty, "pop from empty queue")
  `HCC_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q <= (FIFO_AW+1)'(FIFO_DEPTH), "count out of range")
  `HCC_ASSERT(a_ptr_gap, clk_i, rst_ni, (wr_ptr_q - rd_ptr_q) == cnt_q[FIFO_AW-1:0], "pointers disagree with count")

endmodule

[sv/hcc_back.sv]
// Back end: CMY by a pipelined restoring divider, one quotient bit a stage.
module hcc_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  hcc_pkg::hcc_fifo_stat_t stat_i,
  input  hcc_pkg::hcc_item_t      item_i,
  output logic                    pop_o,
  output logic                    valid_o,
  input  logic                    ready_i,
  output logic [7:0]              cyan_o,
  output logic [7:0]              magenta_o,
  output logic [7:0]              yellow_o,
  output logic [7:0]              black_o
);
  import hcc_pkg::*;

  logic [DIV_STEPS:0] vld_q;
  logic [15:0]        rem_q [DIV_STEPS+1][3];
  logic [15:0]        rem_d [DIV_STEPS+1][3];
  logic [7:0]         quo_q [DIV_STEPS+1][3];
  logic [7:0]         quo_d [DIV_STEPS+1][3];
  logic [7:0]         mx_q  [DIV_STEPS+1];
  logic [7:0]         ch    [3];
  logic [7:0]         diff  [3];
  logic [15:0]        dsr;
  logic               en;

  assign en      = !vld_q[DIV_STEPS] || ready_i;
  assign pop_o   = en && !stat_i.empty;
  assign valid_o = vld_q[DIV_STEPS];

  // load: dividend (max - ch) * 255, then one restoring step per stage
  always_comb begin
    ch[0] = item_i.r;
    ch[1] = item_i.g;
    ch[2] = item_i.b;
    for (int c = 0; c < 3; c++) begin
      diff[c]     = item_i.mx - ch[c];
      rem_d[0][c] = {diff[c], 8'b0} - {8'b0, diff[c]};
      quo_d[0][c] = '0;
    end
    dsr = '0;
    for (int st = 0; st < DIV_STEPS; st++) begin
      dsr = 16'(mx_q[st]) << (DIV_STEPS - 1 - st);
      for (int c = 0; c < 3; c++) begin
        if (rem_q[st][c] >= dsr) begin
          rem_d[st+1][c] = rem_q[st][c] - dsr;
          quo_d[st+1][c] = {quo_q[st][c][6:0], 1'b1};
        end else begin
          rem_d[st+1][c] = rem_q[st][c];
          quo_d[st+1][c] = {quo_q[st][c][6:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[DIV_STEPS-1:0], !stat_i.empty};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mx_q[0] <= item_i.mx;
      for (int st = 1; st <= DIV_STEPS; st++) begin
        mx_q[st] <= mx_q[st-1];
      end
      for (int st = 0; st <= DIV_STEPS; st++) begin
        for (int c = 0; c < 3; c++) begin
          rem_q[st][c] <= rem_d[st][c];
          quo_q[st][c] <= quo_d[st][c];
        end
      end
    end
  end

  // a black pixel has no hue: cyan, magenta and yellow are zero
  assign cyan_o    = (mx_q[DIV_STEPS] == '0) ? '0 : quo_q[DIV_STEPS][0];
  assign magenta_o = (mx_q[DIV_STEPS] == '0) ? '0 : quo_q[DIV_STEPS][1];
  assign yellow_o  = (mx_q[DIV_STEPS] == '0) ? '0 : quo_q[DIV_STEPS][2];
  assign black_o   = 8'd255 - mx_q[DIV_STEPS];

endmodule

[sv/hsv_to_cmyk_pixel_convert.sv]
// Top level of the HSV to CMYK pixel converter.
//
//   channel  direction  tdata fields (low bit first)
//   s_axis   in         hue_deg[8:0], sat_pct[15:9], val_pct[22:16], zero[23]
//   m_axis   out        cyan[7:0], magenta[15:8], yellow[23:16], black[31:24]
//
// One pixel a clock sustained while the receiver is ready.
// Front end: five stages, the widest being the 21x21 multiply by 1/6000.
// The queue write is registered; the back end then pops the entry into its load stage.
// Back end: load stage plus eight restoring divider stages by max, the last one
// being the output register.
// A four-entry queue sits between; each half stalls on its own.
// Reset clears valid bits, queue pointers and the fill count only.
module hsv_to_cmyk_pixel_convert (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // hue_deg, sat_pct, val_pct, pad
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o   // cyan, magenta, yellow, black
);
  import hcc_pkg::*;

  hcc_fifo_stat_t stat;
  hcc_item_t      fr_item, q_item;
  logic           push, pop;
  logic [7:0]     cyan, magenta, yellow, black;

  hcc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid_i),
    .ready_o   (s_axis_tready_o),
    .hue_deg_i (s_axis_tdata_i[8:0]),
    .sat_pct_i (s_axis_tdata_i[15:9]),
    .val_pct_i (s_axis_tdata_i[22:16]),
    .stat_i    (stat),
    .push_o    (push),
    .item_o    (fr_item)
  );

  hcc_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (fr_item),
    .pop_i  (pop),
    .item_o (q_item),
    .stat_o (stat)
  );

  hcc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .stat_i    (stat),
    .item_i    (q_item),
    .pop_o     (pop),
    .valid_o   (m_axis_tvalid_o),
    .ready_i   (m_axis_tready_i),
    .cyan_o    (cyan),
    .magenta_o (magenta),
    .yellow_o  (yellow),
    .black_o   (black)
  );

  assign m_axis_tdata_o = {black, yellow, magenta, cyan};

endmodule

[tb/sv/hsv_to_cmyk_pixel_convert_test.sv]
// Testbench for the HSV to CMYK pixel converter: directed table then random pixels.
`timescale 1ns / 1ps

module hsv_to_cmyk_pixel_convert_test;

  // Pixel fields carried on the stream
  typedef struct packed {
    logic [8:0] hue;
    logic [6:0] sat;
    logic [6:0] val;
  } hsv_px_t;

  typedef struct packed {
    logic [7:0] cyan;
    logic [7:0] magenta;
    logic [7:0] yellow;
    logic [7:0] black;
  } cmyk_px_t;

  // Directed row: pixel, and an optional hand-typed expectation
  typedef struct {
    hsv_px_t  px;
    logic     typed;
    cmyk_px_t want;
  } pixel_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i;  // hue_deg[8:0], sat_pct[15:9], val_pct[22:16], zero[23]
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [31:0] m_axis_tdata_o;  // cyan[7:0], magenta[15:8], yellow[23:16], black[31:24]

  cmyk_px_t    cmyk_pending[$];
  int          fail_cnt;
  bit          no_idle;
  logic        send_done;

  hsv_to_cmyk_pixel_convert dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Colour conversion, fixed point with truncating divisions
  function automatic cmyk_px_t hsv_to_cmyk(hsv_px_t px);
    int unsigned h, s, v, v8, r, g, b, mx, sec, fr, p, q, t;
    cmyk_px_t o;
    h = px.hue;
    s = px.sat;
    v = px.val;
    if (h >= 360) h -= 360;
    if (s > 100) s = 100;
    if (v > 100) v = 100;
    v8 = v * 255 / 100;
    if (s == 0) begin
      r = v8; g = v8; b = v8;
    end else begin
      sec = h / 60;
      fr  = h % 60;
      p = v8 * (100 - s) / 100;
      q = v8 * (6000 - s * fr) / 6000;
      t = v8 * (6000 - s * (60 - fr)) / 6000;
      case (sec)
        0: begin r = v8; g = t;  b = p;  end
        1: begin r = q;  g = v8; b = p;  end
        2: begin r = p;  g = v8; b = t;  end
        3: begin r = p;  g = q;  b = v8; end
        4: begin r = t;  g = p;  b = v8; end
        default: begin r = v8; g = p; b = q; end
      endcase
    end
    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (mx == 0) begin
      o.cyan = '0; o.magenta = '0; o.yellow = '0;
    end else begin
      o.cyan    = 8'((mx - r) * 255 / mx);
      o.magenta = 8'((mx - g) * 255 / mx);
      o.yellow  = 8'((mx - b) * 255 / mx);
    end
    o.black = 8'(255 - mx);
    return o;
  endfunction

  function automatic pixel_row_t mk_row(int h, int s, int v, bit typed,
                                        int c, int m, int y, int k);
    pixel_row_t rw;
    rw.px.hue = 9'(h); rw.px.sat = 7'(s); rw.px.val = 7'(v);
    rw.typed = typed;
    rw.want.cyan = 8'(c); rw.want.magenta = 8'(m);
    rw.want.yellow = 8'(y); rw.want.black = 8'(k);
    return rw;
  endfunction

  function automatic bit idle_now();
    return !no_idle && ($urandom_range(99) < 35);
  endfunction

  // Drive one pixel and queue its expectation on acceptance
  task automatic send_pixel(hsv_px_t px, cmyk_px_t want);
    while (idle_now()) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {1'b0, px.val, px.sat, px.hue};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    cmyk_pending.push_back(want);
    @(negedge clk_i);
  endtask

  // Stimulus
  initial begin
    pixel_row_t rows[$];
    hsv_px_t    px;
    int         n;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    send_done       = 1'b0;
    no_idle         = 1'b0;
    fail_cnt        = 0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // black, white, pure primaries, wrap and saturation of oversized fields; then rows checked by hsv_to_cmyk
    rows.push_back(mk_row(0,   0,   0,   1, 0, 0, 0, 255));
    rows.push_back(mk_row(0,   0,   100, 1, 0, 0, 0, 0));
    rows.push_back(mk_row(0,   100, 100, 1, 0, 255, 255, 0));
    rows.push_back(mk_row(120, 100, 100, 1, 255, 0, 255, 0));
    rows.push_back(mk_row(240, 100, 100, 1, 255, 255, 0, 0));
    rows.push_back(mk_row(360, 100, 100, 1, 0, 255, 255, 0));
    rows.push_back(mk_row(0,   127, 127, 1, 0, 255, 255, 0));
    rows.push_back(mk_row(511, 0,   0,   1, 0, 0, 0, 255));
    rows.push_back(mk_row(300, 100, 0,   1, 0, 0, 0, 255));
    rows.push_back(mk_row(60,  100, 100, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(180, 100, 100, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(300, 100, 100, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(59,  50,  73,  0, 0, 0, 0, 0));
    rows.push_back(mk_row(119, 1,   1,   0, 0, 0, 0, 0));
    rows.push_back(mk_row(359, 99,  99,  0, 0, 0, 0, 0));
    rows.push_back(mk_row(361, 80,  60,  0, 0, 0, 0, 0));
    rows.push_back(mk_row(450, 101, 50,  0, 0, 0, 0, 0));
    rows.push_back(mk_row(200, 0,   55,  0, 0, 0, 0, 0));
    rows.push_back(mk_row(256, 85,  42,  0, 0, 0, 0, 0));
    rows.push_back(mk_row(30,  100, 1,   0, 0, 0, 0, 0));
    foreach (rows[i])
      send_pixel(rows[i].px, rows[i].typed ? rows[i].want : hsv_to_cmyk(rows[i].px));

    // Random pixels, mostly in range; a stretch without idling
    for (n = 0; n < 1950; n++) begin
      no_idle = (n >= 600 && n < 900);
      if ($urandom_range(9) == 0) begin
        px.hue = 9'($urandom); px.sat = 7'($urandom); px.val = 7'($urandom);
      end else begin
        px.hue = 9'($urandom_range(360));
        px.sat = 7'($urandom_range(100));
        px.val = 7'($urandom_range(100));
      end
      send_pixel(px, hsv_to_cmyk(px));
    end
    s_axis_tvalid_i <= 1'b0;
    send_done = 1'b1;
  end

  // Receiver back-pressure
  initial begin
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready_i <= !idle_now();
    end
  end

  // Result check at the rising edge
  always @(posedge clk_i) begin
    cmyk_px_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (cmyk_pending.size() == 0) begin
        $error("unexpected transfer %h", m_axis_tdata_o);
        fail_cnt++;
      end else begin
        want = cmyk_pending.pop_front();
        if (m_axis_tdata_o[7:0] !== want.cyan) begin
          $error("cyan exp %0d got %0d", want.cyan, m_axis_tdata_o[7:0]); fail_cnt++;
        end
        if (m_axis_tdata_o[15:8] !== want.magenta) begin
          $error("magenta exp %0d got %0d", want.magenta, m_axis_tdata_o[15:8]); fail_cnt++;
        end
        if (m_axis_tdata_o[23:16] !== want.yellow) begin
          $error("yellow exp %0d got %0d", want.yellow, m_axis_tdata_o[23:16]); fail_cnt++;
        end
        if (m_axis_tdata_o[31:24] !== want.black) begin
          $error("black exp %0d got %0d", want.black, m_axis_tdata_o[31:24]); fail_cnt++;
        end
      end
    end
  end

  // Drain and verdict
  initial begin
    wait (send_done === 1'b1);
    while (cmyk_pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fail_cnt == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule
